@@ src/mcbq_pkg.sv @@
package mcbq_pkg;

  localparam int MAX_CHANNELS_DEF = 8;

  localparam int SAMPLE_W = 24;
  localparam int CHAN_W   = 4;
  localparam int COEF_W   = 32;
  localparam int STATE_W  = 32;
  localparam int PROD_W   = COEF_W + STATE_W;
  localparam int FRAC_SH  = 28;
  localparam int RND_W    = PROD_W - FRAC_SH;
  localparam int ACC_W    = RND_W + 2;
  localparam int CFG_IDX_W = 3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [CHAN_W-1:0]          channel_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [CHAN_W-1:0]          channel_out;
    logic                       clipped;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0 = 3'd0,
    CFG_B1 = 3'd1,
    CFG_B2 = 3'd2,
    CFG_A1 = 3'd3,
    CFG_A2 = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ADD_D1,
    ADD_D2,
    ADD_ACC,
    ADD_ZERO
  } add_src_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_B0,
    S_B1,
    S_A1,
    S_B2,
    S_A2,
    S_Z2,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    cfg_reg_t mul_coef;
    logic     mul_use_y;
    add_src_t add_src;
    logic     add_sub;
    logic     load_y;
    logic     load_acc;
    logic     load_z1;
    logic     write_state;
    logic     load_out;
    logic     accept;
  } ctrl_t;

  // True when a wide sum does not fit a 32-bit signed word.
  function automatic logic ovf32(input logic signed [ACC_W-1:0] v);
    ovf32 = !((&v[ACC_W-1:STATE_W-1]) || !(|v[ACC_W-1:STATE_W-1]));
  endfunction

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (ovf32(v)) begin
      sat32 = v[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
    end else begin
      sat32 = v[STATE_W-1:0];
    end
  endfunction

  function automatic logic ovf24(input logic signed [STATE_W-1:0] v);
    ovf24 = !((&v[STATE_W-1:SAMPLE_W-1]) || !(|v[STATE_W-1:SAMPLE_W-1]));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [STATE_W-1:0] v);
    if (ovf24(v)) begin
      sat24 = v[STATE_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      sat24 = v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

@@ src/mcbq_mul.sv @@
module mcbq_mul
  import mcbq_pkg::*;
(
  input  logic                     clk,
  input  logic signed [COEF_W-1:0]  coef,
  input  logic signed [STATE_W-1:0] val,
  output logic signed [RND_W-1:0]   rnd
);

  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    prod <= coef * val;
  end

  // Round half up: floor shift plus the first dropped bit.
  assign rnd = prod[PROD_W-1:FRAC_SH] + RND_W'(prod[FRAC_SH-1]);

endmodule

@@ src/mcbq_state.sv @@
module mcbq_state
  import mcbq_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int IDX_W        = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [IDX_W-1:0]          idx,
  input  logic                      we,
  input  logic signed [STATE_W-1:0] wd1,
  input  logic signed [STATE_W-1:0] wd2,
  output logic signed [STATE_W-1:0] rd1,
  output logic signed [STATE_W-1:0] rd2
);

  logic signed [STATE_W-1:0] delay_one [MAX_CHANNELS];
  logic signed [STATE_W-1:0] delay_two [MAX_CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        delay_one[i] <= '0;
        delay_two[i] <= '0;
      end
    end else if (we) begin
      delay_one[idx] <= wd1;
      delay_two[idx] <= wd2;
    end
  end

  assign rd1 = delay_one[idx];
  assign rd2 = delay_two[idx];

endmodule

@@ src/mcbq_ctrl.sv @@
module mcbq_ctrl
  import mcbq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  is_pass,
  input  logic  out_free,
  output logic  in_ready,
  output ctrl_t ctl
);

  seq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = is_pass ? S_DONE : S_B0;
        end
      end
      S_B0: state_next = S_B1;
      S_B1: state_next = S_A1;
      S_A1: state_next = S_B2;
      S_B2: state_next = S_A2;
      S_A2: state_next = S_Z2;
      S_Z2: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl             = '0;
    ctl.mul_coef    = CFG_B0;
    ctl.add_src     = ADD_ZERO;
    in_ready        = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
      end
      S_B0: ctl.mul_coef = CFG_B0;
      S_B1: begin
        ctl.mul_coef = CFG_B1;
        ctl.add_src  = ADD_D1;
        ctl.load_y   = 1'b1;
      end
      S_A1: begin
        ctl.mul_coef  = CFG_A1;
        ctl.mul_use_y = 1'b1;
        ctl.add_src   = ADD_D2;
        ctl.load_acc  = 1'b1;
      end
      S_B2: begin
        ctl.mul_coef = CFG_B2;
        ctl.add_src  = ADD_ACC;
        ctl.add_sub  = 1'b1;
        ctl.load_z1  = 1'b1;
      end
      S_A2: begin
        ctl.mul_coef  = CFG_A2;
        ctl.mul_use_y = 1'b1;
        ctl.add_src   = ADD_ZERO;
        ctl.load_acc  = 1'b1;
      end
      S_Z2: begin
        ctl.add_src     = ADD_ACC;
        ctl.add_sub     = 1'b1;
        ctl.write_state = 1'b1;
      end
      S_DONE: ctl.load_out = out_free;
      default: ctl.accept = 1'b0;
    endcase
  end

endmodule

@@ src/multichannel_biquad_df2t.sv @@
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | in_data (sample_in, channel_in)
// out     | output    | out_valid / out_ready  | out_data (sample_out, channel_out, clipped)
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A filtered sample is offered as a result once the sequencer has run through its steps,
// and the next sample is taken only once that result is loaded, so one sample is worked
// on at a time: one shared 32 x 32 multiplier forms the five products in turn, and one
// shared adder with saturation folds them in. A sample on a channel at or above
// MAX_CHANNELS skips the steps, goes straight to the output register and leaves the state
// untouched. Synchronous reset returns the coefficients to unity pass-through and clears
// both delay registers of every channel at once. A result waiting on out_ready does not
// stop the next input transfer; the sequencer only stalls at its final step until the
// output register is free. Coefficient writes are always taken.
module multichannel_biquad_df2t
  import mcbq_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Coefficient registers, Q3.28.
  logic signed [COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  // Item held for the duration of its sequence.
  logic signed [SAMPLE_W-1:0] x;
  logic [CHAN_W-1:0]          ch;
  logic                       pass;

  // Working registers: fed-back output, first new delay, partial sum, clip flag.
  logic signed [STATE_W-1:0] y;
  logic signed [STATE_W-1:0] z1;
  logic signed [ACC_W-1:0]   acc;
  logic                      clip;

  ctrl_t ctl;
  logic  is_pass;
  logic  out_free;

  logic signed [COEF_W-1:0]  mul_coef;
  logic signed [STATE_W-1:0] mul_val;
  logic signed [RND_W-1:0]   rnd;
  logic signed [ACC_W-1:0]   add_a;
  logic signed [ACC_W-1:0]   add_b;
  logic signed [ACC_W-1:0]   sum;
  logic signed [STATE_W-1:0] rd1, rd2;

  assign cfg_ready = 1'b1;

  // Coefficient writes; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= 32'sh1000_0000;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_B0:  coef_b0 <= cfg_data;
        CFG_B1:  coef_b1 <= cfg_data;
        CFG_B2:  coef_b2 <= cfg_data;
        CFG_A1:  coef_a1 <= cfg_data;
        CFG_A2:  coef_a2 <= cfg_data;
        default: coef_b0 <= coef_b0;
      endcase
    end
  end

  assign is_pass  = {1'b0, in_data.channel_in} >= (CHAN_W + 1)'(MAX_CHANNELS);
  assign out_free = !out_valid || out_ready;

  mcbq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .is_pass  (is_pass),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (ctl.mul_coef)
      CFG_B0:  mul_coef = coef_b0;
      CFG_B1:  mul_coef = coef_b1;
      CFG_B2:  mul_coef = coef_b2;
      CFG_A1:  mul_coef = coef_a1;
      CFG_A2:  mul_coef = coef_a2;
      default: mul_coef = coef_b0;
    endcase
  end

  assign mul_val = ctl.mul_use_y ? y : STATE_W'(x);

  mcbq_mul u_mul (
    .clk  (clk),
    .coef (mul_coef),
    .val  (mul_val),
    .rnd  (rnd)
  );

  mcbq_state #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .IDX_W        (IDX_W)
  ) u_state (
    .clk (clk),
    .rst (rst),
    .idx (ch[IDX_W-1:0]),
    .we  (ctl.write_state),
    .wd1 (z1),
    .wd2 (sat32(sum)),
    .rd1 (rd1),
    .rd2 (rd2)
  );

  // The shared adder: a delay register, the partial sum or zero, plus or minus the
  // rounded product that the multiplier delivers in this cycle.
  always_comb begin
    case (ctl.add_src)
      ADD_D1:  add_a = ACC_W'(rd1);
      ADD_D2:  add_a = ACC_W'(rd2);
      ADD_ACC: add_a = acc;
      default: add_a = '0;
    endcase
  end

  assign add_b = ACC_W'(rnd);
  assign sum   = ctl.add_sub ? (add_a - add_b) : (add_a + add_b);

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      x    <= in_data.sample_in;
      ch   <= in_data.channel_in;
      pass <= is_pass;
      clip <= 1'b0;
    end else if (ctl.load_y || ctl.load_z1 || ctl.write_state) begin
      clip <= clip | ovf32(sum);
    end
    if (ctl.load_y) begin
      y <= sat32(sum);
    end
    if (ctl.load_z1) begin
      z1 <= sat32(sum);
    end
    if (ctl.load_acc) begin
      acc <= sum;
    end
  end

  // Output register: held until the consumer completes the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_data.channel_out <= ch;
      if (pass) begin
        out_data.sample_out <= x;
        out_data.clipped    <= 1'b0;
      end else begin
        out_data.sample_out <= sat24(y);
        out_data.clipped    <= clip | ovf24(y);
      end
    end
  end

  // Once a sample is taken, the input stays closed while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again straight after a transfer");

  // A pass-through channel never reports clipping.
  a_pass_no_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid && ({1'b0, out_data.channel_out} >= (CHAN_W + 1)'(MAX_CHANNELS))
    |-> !out_data.clipped)
    else $error("clip flag set on a pass-through channel");

  // A new result appears only from the final step of the sequence.
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.load_out))
    else $error("result offered without the sequencer finishing");

  // Pass-through samples leave the delay registers alone.
  a_pass_no_write: assert property (@(posedge clk) disable iff (rst)
    ctl.write_state |-> !pass)
    else $error("state written for a pass-through channel");

endmodule

@@ tb/sv/tb_multichannel_biquad_df2t.sv @@
`timescale 1ns / 100ps

module tb_multichannel_biquad_df2t;
  import mcbq_pkg::*;

  localparam int NUM_CH        = MAX_CHANNELS_DEF;
  localparam int NUM_COEFS     = int'(CFG_A2) + 1;
  // Idle time after the last result transfer, long enough to leave the block well and
  // truly at rest before a coefficient write.
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int TIMEOUT_NS    = 1000000;
  localparam int RANDOM_BLOCKS = 4;
  localparam int BLOCK_ITEMS   = 119;

  localparam logic [COEF_W-1:0] COEF_MAX  = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN  = 32'h8000_0000;
  localparam logic [COEF_W-1:0] COEF_ZERO = 32'h0000_0000;
  localparam logic [COEF_W-1:0] COEF_ONE  = 32'h1000_0000;
  localparam logic [COEF_W-1:0] COEF_HALF = 32'h0800_0000;
  localparam logic [COEF_W-1:0] COEF_NEG1 = 32'hF000_0000;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7F_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh80_0000;

  localparam logic [CHAN_W-1:0] CH_LAST_FILT = CHAN_W'(NUM_CH - 1);
  localparam logic [CHAN_W-1:0] CH_FIRST_PASS = CHAN_W'(NUM_CH);
  localparam logic [CHAN_W-1:0] CH_TOP       = CHAN_W'((1 << CHAN_W) - 1);

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  // Percentages of cycles in which the sender holds back and the receiver refuses a
  // transfer. The test tasks change them between phases.
  int gap_pct;
  int stall_pct;
  int error_cnt;

  // Our own copy of the filter: coefficients in Q3.28 and the two delay lines in Q8.23.
  longint coef_q28 [NUM_COEFS];
  longint delay_one_q23 [NUM_CH];
  longint delay_two_q23 [NUM_CH];

  // Outputs that have been predicted for accepted samples and not yet seen.
  out_item_t awaited_outputs [$];

  multichannel_biquad_df2t #(
    .MAX_CHANNELS(NUM_CH)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver refuses transfers at random, at the rate the current phase asks for.
  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // A product of a Q3.28 coefficient and a Q.23 value, rounded back to 23 fractional
  // bits with the half-way case going towards plus infinity.
  function automatic longint round_product(longint coef, longint value);
    return (coef * value + (longint'(1) <<< (FRAC_SH - 1))) >>> FRAC_SH;
  endfunction

  function automatic longint saturate(longint value, int width, inout bit clip);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (width - 1)) - 1;
    lo = -hi - 1;
    if (value > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (value < lo) begin
      clip = 1'b1;
      return lo;
    end
    return value;
  endfunction

  // Works out the output for one sample and, for a filtered channel, advances its delay lines.
  function automatic out_item_t filter_sample(in_item_t item);
    out_item_t res;
    longint    x;
    longint    y;
    longint    z1;
    longint    z2;
    bit        clip;
    clip            = 1'b0;
    x               = longint'($signed(item.sample_in));
    res.channel_out = item.channel_in;
    if (item.channel_in >= NUM_CH) begin
      // Channels beyond the filtered range go straight through and touch no state.
      res.sample_out = item.sample_in;
      res.clipped    = 1'b0;
      return res;
    end
    y  = saturate(round_product(coef_q28[CFG_B0], x) + delay_one_q23[item.channel_in],
                  STATE_W, clip);
    z1 = saturate(round_product(coef_q28[CFG_B1], x) + delay_two_q23[item.channel_in]
                  - round_product(coef_q28[CFG_A1], y), STATE_W, clip);
    z2 = saturate(round_product(coef_q28[CFG_B2], x) - round_product(coef_q28[CFG_A2], y),
                  STATE_W, clip);
    delay_one_q23[item.channel_in] = z1;
    delay_two_q23[item.channel_in] = z2;
    y              = saturate(y, SAMPLE_W, clip);
    res.sample_out = y[SAMPLE_W-1:0];
    res.clipped    = clip;
    return res;
  endfunction

  task automatic note_error(string what);
    error_cnt++;
    if (error_cnt <= 10) begin
      $display("%0t ns: %s", $realtime, what);
    end
  endtask

  // Checks every result transfer against the oldest outstanding prediction. The outputs
  // are sampled at the clock edge itself, before anything scheduled for that edge lands.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_outputs.size() == 0) begin
        note_error($sformatf("result with nothing outstanding: sample %0d ch %0d clip %0b",
                             $signed(out_data.sample_out), out_data.channel_out,
                             out_data.clipped));
      end else begin
        want = awaited_outputs.pop_front();
        if (out_data.sample_out !== want.sample_out ||
            out_data.channel_out !== want.channel_out ||
            out_data.clipped !== want.clipped) begin
          note_error($sformatf({"mismatch: want sample %0d ch %0d clip %0b, ",
                                "got sample %0d ch %0d clip %0b"},
                               $signed(want.sample_out), want.channel_out, want.clipped,
                               $signed(out_data.sample_out), out_data.channel_out,
                               out_data.clipped));
        end
      end
    end
  end

  // Offers one sample and waits for its transfer. Valid is left high afterwards, so a
  // following sample is offered without a break; a gap lowers it first.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] sample, logic [CHAN_W-1:0] chan);
    in_item_t item;
    item.sample_in  = sample;
    item.channel_in = chan;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    awaited_outputs.push_back(filter_sample(item));
  endtask

  // Coefficients may only change while the filter is at rest: no sample offered, every
  // predicted result seen, and the sequencer given time to fall back to idle.
  task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
    in_valid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // Indices beyond the last coefficient are accepted and then dropped.
    if (idx <= CFG_A2) begin
      coef_q28[idx] = longint'($signed(value));
    end
  endtask

  task automatic set_coefs(logic [COEF_W-1:0] b0, logic [COEF_W-1:0] b1,
                           logic [COEF_W-1:0] b2, logic [COEF_W-1:0] a1,
                           logic [COEF_W-1:0] a2);
    write_coef(CFG_B0, b0);
    write_coef(CFG_B1, b1);
    write_coef(CFG_B2, b2);
    write_coef(CFG_A1, a1);
    write_coef(CFG_A2, a2);
  endtask

  // A coefficient drawn either anywhere in the 32-bit range, at one of its ends, or
  // within +/- span in Q3.28.
  function automatic logic [COEF_W-1:0] random_coef(int unsigned span, bit wild);
    if (wild) begin
      case ($urandom_range(3))
        0:       return COEF_MAX;
        1:       return COEF_MIN;
        default: return $urandom();
      endcase
    end
    return $urandom_range(2 * span) - span;
  endfunction

  // Modest samples half of the time so that the recursion runs without clipping, with full-range
  // values and the extremes mixed in.
  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(9))
      0:             return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      1, 2, 3, 4:    return SAMPLE_W'($urandom());
      default:       return SAMPLE_W'($urandom_range(131072) - 65536);
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] random_channel();
    if ($urandom_range(9) < 8) begin
      return CHAN_W'($urandom_range(NUM_CH - 1));
    end
    return CHAN_W'($urandom_range((1 << CHAN_W) - 1));
  endfunction

  // With the coefficients straight out of reset the filter is a unity gain, so every
  // channel should echo its input; channels above the filtered range pass through.
  task automatic test_unity_after_reset();
    send_sample(SAMPLE_MAX, 0);
    send_sample(SAMPLE_MIN, 0);
    send_sample('0, 0);
    send_sample(-1, 0);
    send_sample(1, 0);
    send_sample(24'sh12_3456, CH_LAST_FILT);
    send_sample(SAMPLE_MIN, CH_FIRST_PASS);
    send_sample(SAMPLE_MAX, CH_TOP);
    send_sample(-1, CH_TOP);
  endtask

  // Coefficients at their ends drive y, both delay lines and the 24-bit output into
  // saturation, which must raise the clip flag; the pass-through channels must not.
  task automatic test_saturation();
    set_coefs(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
    send_sample(SAMPLE_MAX, 1);
    send_sample(SAMPLE_MAX, 1);
    send_sample(SAMPLE_MIN, 1);
    send_sample(SAMPLE_MIN, 1);
    send_sample(SAMPLE_MAX, CH_TOP);
    send_sample(SAMPLE_MIN, CH_FIRST_PASS);
  endtask

  // An impulse through a resonant section exercises the feedback path, and half of one
  // LSB either side of zero checks that rounding goes towards plus infinity.
  task automatic test_feedback_and_rounding();
    set_coefs(COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_NEG1, COEF_HALF);
    send_sample(24'sh40_0000, 2);
    repeat (5) send_sample('0, 2);
    send_sample(1, 3);
    send_sample(-1, 3);
  endtask

  // Writes to indices past the last coefficient must leave the filter as it was.
  task automatic test_unused_index();
    for (int k = int'(CFG_A2) + 1; k < (1 << CFG_IDX_W); k++) begin
      write_coef(CFG_IDX_W'(k), $urandom());
    end
    send_sample(24'sh20_0000, 4);
    send_sample(-24'sh20_0000, 4);
  endtask

  // Random traffic in blocks, each under a fresh set of coefficients. A quarter of the
  // sets are wild and will mostly saturate; the rest keep the recursion in range often
  // enough for long stretches of real filtering.
  task automatic test_random_traffic(int sender_gap, int receiver_stall);
    bit wild;
    gap_pct   = sender_gap;
    stall_pct = receiver_stall;
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      wild = ($urandom_range(3) == 0);
      set_coefs(random_coef(32'h1000_0000, wild), random_coef(32'h1000_0000, wild),
                random_coef(32'h1000_0000, wild), random_coef(32'h1E00_0000, wild),
                random_coef(32'h0E00_0000, wild));
      repeat (BLOCK_ITEMS) send_sample(random_sample(), random_channel());
    end
  endtask

  initial begin
    int spins;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    gap_pct   = 0;
    stall_pct = 0;
    error_cnt = 0;
    coef_q28[CFG_B0] = longint'($signed(COEF_ONE));
    coef_q28[CFG_B1] = 0;
    coef_q28[CFG_B2] = 0;
    coef_q28[CFG_A1] = 0;
    coef_q28[CFG_A2] = 0;
    for (int c = 0; c < NUM_CH; c++) begin
      delay_one_q23[c] = 0;
      delay_two_q23[c] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_unity_after_reset();
    test_saturation();
    test_feedback_and_rounding();
    test_unused_index();
    test_random_traffic(0, 0);
    test_random_traffic(61, 0);
    test_random_traffic(0, 61);
    test_random_traffic(20, 20);

    // Stop offering samples, let the receiver take everything, then allow a little slack
    // for any stray result before the verdict.
    in_valid <= 1'b0;
    gap_pct   = 0;
    stall_pct = 0;
    spins     = 0;
    while (awaited_outputs.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    if (awaited_outputs.size() != 0) begin
      note_error($sformatf("%0d results never arrived", awaited_outputs.size()));
    end
    repeat (20) @(posedge clk);
    if (error_cnt == 0) begin
      $display("tb_multichannel_biquad_df2t: clean");
    end else begin
      $display("tb_multichannel_biquad_df2t: errors");
    end
    $finish;
  end

  // Safety net in case a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_multichannel_biquad_df2t: errors");
    $finish;
  end

endmodule
